>>> rtl/core/pfc_pkg.sv
// Shared types and constants for the pixel format converter.
// No dependencies; imported by every module of the converter.
package pfc_pkg;

   // destination address width (byte offsets wrap at this width)
   localparam int DST_ADDR_BITS = 34;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 18;

   // pixel queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SRC_FORMAT    = 3'd0,
      CSR_DST_FORMAT    = 3'd1,
      CSR_IMAGE_WIDTH   = 3'd2,
      CSR_IMAGE_HEIGHT  = 3'd3,
      CSR_SRC_ROW_BYTES = 3'd4,
      CSR_DST_ROW_BYTES = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      SRC_RGB24   = 4'd0,
      SRC_BGR24   = 4'd1,
      SRC_RGB16BE = 4'd2,
      SRC_RGB16LE = 4'd3,
      SRC_BGR16BE = 4'd4,
      SRC_BGR16LE = 4'd5,
      SRC_ARGB32  = 4'd6,
      SRC_BGRA32  = 4'd7,
      SRC_RGBA32  = 4'd8,
      SRC_ABGR32  = 4'd9,
      SRC_BGR032  = 4'd10
   } src_format_type;

   typedef enum logic [1:0] {
      DST_BGR032 = 2'd0,
      DST_ARGB32 = 2'd1,
      DST_RGB565 = 2'd2
   } dst_format_type;

   // one converted destination pixel, as queued from front to back
   typedef struct packed {
      logic [31:0]              bytes;      // first byte at bits 7..0
      logic                     wide;       // four bytes, else two
      logic [DST_ADDR_BITS-1:0] addr;       // offset of the first byte
      logic                     frame_end;  // last pixel of the image
   } pixel_word_type;

endpackage

>>> rtl/core/pixel_format_converter_top.sv
// Top level of the pixel format converter: front end, pixel queue, back end.
// Depends on pfc_pkg, pfc_front, pfc_queue and pfc_back.
//
// Source bytes are pushed one per word and destination bytes come out one per
// word with their byte offset, a pixel-last and a frame-last flag. The front
// end takes one source byte per cycle while the queue is not full (pad bytes
// and partial pixels make no output) and hands each finished pixel to a
// four-entry queue. The back end emits one destination byte per cycle while its
// output register is free, so in steady state a pixel is paced by the larger of
// its source and destination byte counts, with row pad bytes added on the source
// side. Configuration is written through the csr_ port; the user must write it
// only while no image is in flight, as the block does not enforce this. After
// reset the block is ready at once.
module pixel_format_converter_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [pfc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pfc_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [7:0]                     req_src_byte,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [7:0]                     rsp_dst_byte,
   output logic [pfc_pkg::DST_ADDR_BITS-1:0] rsp_dst_addr,
   output logic                           rsp_pixel_last,
   output logic                           rsp_frame_last
);
   import pfc_pkg::*;

   logic           queue_push, queue_full, queue_pop, queue_empty;
   pixel_word_type push_word, head_word;

   assign req_full = queue_full;

   // accept and convert source bytes
   pfc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_push         (req_push),
      .req_src_byte     (req_src_byte),
      .queue_full       (queue_full),
      .queue_push       (queue_push),
      .queue_word       (push_word)
   );

   // decouple the two ends
   pfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_word (push_word),
      .full      (queue_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .head_word (head_word)
   );

   // emit destination bytes
   pfc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .queue_word     (head_word),
      .queue_pop      (queue_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_dst_byte   (rsp_dst_byte),
      .rsp_dst_addr   (rsp_dst_addr),
      .rsp_pixel_last (rsp_pixel_last),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

>>> rtl/core/pfc_front.sv
// Front end: configuration registers, row padding skip, pixel assembly,
// format conversion and destination addressing. Depends on pfc_pkg.
module pfc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [pfc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pfc_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                           req_push,
   input  logic [7:0]                     req_src_byte,
   input  logic                           queue_full,
   output logic                           queue_push,
   output pfc_pkg::pixel_word_type        queue_word
);
   import pfc_pkg::*;

   // configuration
   logic [3:0]  src_format_ff;
   logic [1:0]  dst_format_ff;
   logic [15:0] image_width_ff;
   logic [15:0] image_height_ff;
   logic [17:0] src_row_bytes_ff;
   logic [17:0] dst_row_bytes_ff;

   // walk state
   logic [1:0]               byte_in_pixel_ff, byte_in_pixel_in;
   logic [23:0]              pixel_bytes_ff, pixel_bytes_in;
   logic [15:0]              column_count_ff, column_count_in;
   logic [15:0]              row_count_ff, row_count_in;
   logic [17:0]              pad_remaining_ff, pad_remaining_in;
   logic [DST_ADDR_BITS-1:0] dst_row_base_ff, dst_row_base_in;
   logic [DST_ADDR_BITS-1:0] dst_pos_ff, dst_pos_in;

   logic                     accept;
   logic                     image_empty;
   logic [2:0]               src_size;
   logic                     dst_wide;
   logic                     pixel_done;
   logic [7:0]               by0, by1, by2, by3;
   logic [7:0]               red, green, blue;
   logic [31:0]              out_bytes;
   logic                     row_end, frame_end;
   logic [17:0]              src_len, dst_len, pad_len;
   logic [DST_ADDR_BITS-1:0] row_step;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_format_ff    <= '0;
         dst_format_ff    <= '0;
         image_width_ff   <= '0;
         image_height_ff  <= '0;
         src_row_bytes_ff <= '0;
         dst_row_bytes_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SRC_FORMAT:    src_format_ff    <= csr_write_data[3:0];
            CSR_DST_FORMAT:    dst_format_ff    <= csr_write_data[1:0];
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_write_data[15:0];
            CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_write_data[15:0];
            CSR_SRC_ROW_BYTES: src_row_bytes_ff <= csr_write_data;
            CSR_DST_ROW_BYTES: dst_row_bytes_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign accept      = req_push && !queue_full;
   assign image_empty = (image_width_ff == '0) || (image_height_ff == '0);
   assign dst_wide    = (dst_format_ff != DST_RGB565);

   // source pixel size; unused codes fall back to three bytes
   always_comb begin
      if (src_format_ff inside {SRC_RGB24, SRC_BGR24} || src_format_ff > SRC_BGR032)
         src_size = 3'd3;
      else if (src_format_ff <= SRC_BGR16LE)
         src_size = 3'd2;
      else
         src_size = 3'd4;
   end

   assign pixel_done = ({1'b0, byte_in_pixel_ff} + 3'd1) >= src_size;

   // collect pixel bytes, the incoming one lands at the last slot
   always_comb begin
      by0 = pixel_bytes_ff[7:0];
      by1 = pixel_bytes_ff[15:8];
      by2 = pixel_bytes_ff[23:16];
      by3 = 8'h00;
      case (src_size)
         3'd2:    by1 = req_src_byte;
         3'd3:    by2 = req_src_byte;
         default: by3 = req_src_byte;
      endcase
   end

   // unpack to 8-bit channels
   always_comb begin
      case (src_format_ff)
         SRC_BGR24, SRC_BGRA32, SRC_BGR032: begin
            blue = by0; green = by1; red = by2;
         end
         SRC_RGB16BE: begin
            red = {by0[7:3], 3'b000}; green = {by0[2:0], by1[7:5], 2'b00};
            blue = {by1[4:0], 3'b000};
         end
         SRC_RGB16LE: begin
            red = {by1[7:3], 3'b000}; green = {by1[2:0], by0[7:5], 2'b00};
            blue = {by0[4:0], 3'b000};
         end
         SRC_BGR16BE: begin
            blue = {by0[7:3], 3'b000}; green = {by0[2:0], by1[7:5], 2'b00};
            red = {by1[4:0], 3'b000};
         end
         SRC_BGR16LE: begin
            blue = {by1[7:3], 3'b000}; green = {by1[2:0], by0[7:5], 2'b00};
            red = {by0[4:0], 3'b000};
         end
         SRC_ARGB32: begin
            red = by1; green = by2; blue = by3;
         end
         SRC_ABGR32: begin
            blue = by1; green = by2; red = by3;
         end
         default: begin
            red = by0; green = by1; blue = by2;
         end
      endcase
   end

   // pack to destination layout
   always_comb begin
      case (dst_format_ff)
         DST_ARGB32: out_bytes = {blue, green, red, 8'hff};
         DST_RGB565: out_bytes = {16'h0000, red[7:3], green[7:5], green[4:2], blue[7:3]};
         default:    out_bytes = {8'h00, red, green, blue};
      endcase
   end

   // row geometry
   assign row_end   = ({1'b0, column_count_ff} + 17'd1) >= {1'b0, image_width_ff};
   assign frame_end = row_end &&
                      (({1'b0, row_count_ff} + 17'd1) >= {1'b0, image_height_ff});

   always_comb begin
      case (src_size)
         3'd2:    src_len = {1'b0, image_width_ff, 1'b0};
         3'd3:    src_len = {1'b0, image_width_ff, 1'b0} + {2'b00, image_width_ff};
         default: src_len = {image_width_ff, 2'b00};
      endcase
      dst_len  = dst_wide ? {image_width_ff, 2'b00} : {1'b0, image_width_ff, 1'b0};
      pad_len  = (src_row_bytes_ff > src_len) ? (src_row_bytes_ff - src_len) : '0;
      row_step = (dst_row_bytes_ff > dst_len) ?
                 DST_ADDR_BITS'(dst_row_bytes_ff) : DST_ADDR_BITS'(dst_len);
   end

   // advance the walk state
   always_comb begin
      byte_in_pixel_in = byte_in_pixel_ff;
      pixel_bytes_in   = pixel_bytes_ff;
      column_count_in  = column_count_ff;
      row_count_in     = row_count_ff;
      pad_remaining_in = pad_remaining_ff;
      dst_row_base_in  = dst_row_base_ff;
      dst_pos_in       = dst_pos_ff;
      queue_push       = 1'b0;
      if (accept && !image_empty) begin
         if (pad_remaining_ff != '0) begin
            pad_remaining_in = pad_remaining_ff - 18'd1;
         end else if (!pixel_done) begin
            case (byte_in_pixel_ff)
               2'd0:    pixel_bytes_in[7:0]   = req_src_byte;
               2'd1:    pixel_bytes_in[15:8]  = req_src_byte;
               default: pixel_bytes_in[23:16] = req_src_byte;
            endcase
            byte_in_pixel_in = byte_in_pixel_ff + 2'd1;
         end else begin
            queue_push       = 1'b1;
            byte_in_pixel_in = '0;
            pixel_bytes_in   = '0;
            if (row_end) begin
               pad_remaining_in = pad_len;
               column_count_in  = '0;
               if (frame_end) begin
                  row_count_in    = '0;
                  dst_row_base_in = '0;
                  dst_pos_in      = '0;
               end else begin
                  row_count_in    = row_count_ff + 16'd1;
                  dst_row_base_in = dst_row_base_ff + row_step;
                  dst_pos_in      = dst_row_base_ff + row_step;
               end
            end else begin
               column_count_in = column_count_ff + 16'd1;
               dst_pos_in      = dst_pos_ff + (dst_wide ? DST_ADDR_BITS'(4)
                                                        : DST_ADDR_BITS'(2));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_in_pixel_ff <= '0;
         pixel_bytes_ff   <= '0;
         column_count_ff  <= '0;
         row_count_ff     <= '0;
         pad_remaining_ff <= '0;
         dst_row_base_ff  <= '0;
         dst_pos_ff       <= '0;
      end else begin
         byte_in_pixel_ff <= byte_in_pixel_in;
         pixel_bytes_ff   <= pixel_bytes_in;
         column_count_ff  <= column_count_in;
         row_count_ff     <= row_count_in;
         pad_remaining_ff <= pad_remaining_in;
         dst_row_base_ff  <= dst_row_base_in;
         dst_pos_ff       <= dst_pos_in;
      end
   end

   // converted pixel word
   always_comb begin
      queue_word.bytes     = out_bytes;
      queue_word.wide      = dst_wide;
      queue_word.addr      = dst_pos_ff;
      queue_word.frame_end = frame_end;
   end

endmodule

>>> rtl/core/pfc_queue.sv
// Short queue of converted pixel words between front and back end.
// Depends on pfc_pkg for the word type and depth.
module pfc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pfc_pkg::pixel_word_type push_word,
   output logic                    full,
   input  logic                    pop,
   output logic                    empty,
   output pfc_pkg::pixel_word_type head_word
);
   import pfc_pkg::*;

   pixel_word_type            entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      do_push, do_pop;

   assign full      = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_word = entries_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed word
   always_ff @(posedge clock) begin
      if (do_push)
         entries_ff[wr_ptr_ff] <= push_word;
   end

endmodule

>>> rtl/core/pfc_back.sv
// Back end: splits queued pixel words into destination bytes and holds
// the result word in an output register. Depends on pfc_pkg.
module pfc_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           queue_empty,
   input  pfc_pkg::pixel_word_type        queue_word,
   output logic                           queue_pop,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [7:0]                     rsp_dst_byte,
   output logic [pfc_pkg::DST_ADDR_BITS-1:0] rsp_dst_addr,
   output logic                           rsp_pixel_last,
   output logic                           rsp_frame_last
);
   import pfc_pkg::*;

   // pixel being split
   logic                     cur_valid_ff, cur_valid_in;
   pixel_word_type           cur_word_ff, cur_word_in;
   logic [1:0]               index_ff, index_in;

   // output register
   logic                     out_valid_ff, out_valid_in;
   logic [7:0]               out_byte_ff, out_byte_in;
   logic [DST_ADDR_BITS-1:0] out_addr_ff, out_addr_in;
   logic                     out_pixel_last_ff, out_pixel_last_in;
   logic                     out_frame_last_ff, out_frame_last_in;

   logic                     slot_free;
   logic                     emit;
   logic                     last_byte;
   logic [7:0]               cur_byte;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign emit      = cur_valid_ff && slot_free;
   assign last_byte = cur_word_ff.wide ? (index_ff == 2'd3) : (index_ff == 2'd1);
   assign queue_pop = !queue_empty && (!cur_valid_ff || (emit && last_byte));

   always_comb begin
      case (index_ff)
         2'd0:    cur_byte = cur_word_ff.bytes[7:0];
         2'd1:    cur_byte = cur_word_ff.bytes[15:8];
         2'd2:    cur_byte = cur_word_ff.bytes[23:16];
         default: cur_byte = cur_word_ff.bytes[31:24];
      endcase
   end

   // step through the bytes of the current pixel, refill from the queue
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_word_in  = cur_word_ff;
      index_in     = index_ff;
      if (emit) begin
         index_in = index_ff + 2'd1;
         if (last_byte)
            cur_valid_in = 1'b0;
      end
      if (queue_pop) begin
         cur_valid_in = 1'b1;
         cur_word_in  = queue_word;
         index_in     = '0;
      end
   end

   // load the output register
   always_comb begin
      out_valid_in      = out_valid_ff;
      out_byte_in       = out_byte_ff;
      out_addr_in       = out_addr_ff;
      out_pixel_last_in = out_pixel_last_ff;
      out_frame_last_in = out_frame_last_ff;
      if (rsp_pop)
         out_valid_in = 1'b0;
      if (emit) begin
         out_valid_in      = 1'b1;
         out_byte_in       = cur_byte;
         out_addr_in       = cur_word_ff.addr + DST_ADDR_BITS'(index_ff);
         out_pixel_last_in = last_byte;
         out_frame_last_in = last_byte && cur_word_ff.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         index_ff     <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         index_ff     <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_word_ff       <= cur_word_in;
      out_byte_ff       <= out_byte_in;
      out_addr_ff       <= out_addr_in;
      out_pixel_last_ff <= out_pixel_last_in;
      out_frame_last_ff <= out_frame_last_in;
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_dst_byte   = out_byte_ff;
   assign rsp_dst_addr   = out_addr_ff;
   assign rsp_pixel_last = out_pixel_last_ff;
   assign rsp_frame_last = out_frame_last_ff;

endmodule

>>> bench/pixel_format_converter_checker.sv
// Scoreboard for the pixel format converter: tracks the register settings and the
// source bytes accepted by the block, predicts every destination word and compares it.
// Depends on pfc_pkg only.
`timescale 1ns / 100ps

module pixel_format_converter_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [pfc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pfc_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                               req_push,
   input  logic                               req_full,
   input  logic [7:0]                         req_src_byte,
   input  logic                               rsp_empty,
   input  logic                               rsp_pop,
   input  logic [7:0]                         rsp_dst_byte,
   input  logic [pfc_pkg::DST_ADDR_BITS-1:0]  rsp_dst_addr,
   input  logic                               rsp_pixel_last,
   input  logic                               rsp_frame_last,
   output int                                 mismatch_count,
   output int                                 words_waiting,
   output int                                 words_checked
);
   import pfc_pkg::*;

   localparam int PRINT_CAP = 40;

   typedef struct {
      logic [7:0]               value;
      logic [DST_ADDR_BITS-1:0] offset;
      logic                     pixel_end;
      logic                     image_end;
   } dst_word_type;

   // predicted destination words, oldest first
   dst_word_type expected_words[$];

   // register copies
   logic [3:0]  src_fmt;
   logic [1:0]  dst_fmt;
   logic [15:0] width;
   logic [15:0] height;
   logic [17:0] src_pitch;
   logic [17:0] dst_pitch;

   // converter position
   logic [1:0]               byte_count;
   logic [23:0]              held_bytes;
   logic [15:0]              column;
   logic [15:0]              row;
   logic [17:0]              pad_left;
   logic [DST_ADDR_BITS-1:0] row_base;
   logic [DST_ADDR_BITS-1:0] pixel_offset;

   int mismatches = 0;
   int checked    = 0;

   task automatic report_mismatch(input string what, input longint seen,
                                  input longint wanted);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t: mismatch, %s: got 0x%0h, expected 0x%0h", $realtime, what, seen,
                  wanted);
   endtask

   // compare one popped word against the oldest prediction
   task automatic check_word();
      dst_word_type want;
      if (expected_words.size() == 0) begin
         report_mismatch("word with nothing expected, offset", longint'(rsp_dst_addr), 0);
      end else begin
         want = expected_words.pop_front();
         checked++;
         if (rsp_dst_byte !== want.value)
            report_mismatch("dst_byte", longint'(rsp_dst_byte), longint'(want.value));
         if (rsp_dst_addr !== want.offset)
            report_mismatch("dst_addr", longint'(rsp_dst_addr), longint'(want.offset));
         if (rsp_pixel_last !== want.pixel_end)
            report_mismatch("pixel_last", longint'(rsp_pixel_last),
                            longint'(want.pixel_end));
         if (rsp_frame_last !== want.image_end)
            report_mismatch("frame_last", longint'(rsp_frame_last),
                            longint'(want.image_end));
      end
   endtask

   task automatic store_setting();
      case (csr_index)
         CSR_SRC_FORMAT:    src_fmt   = csr_write_data[3:0];
         CSR_DST_FORMAT:    dst_fmt   = csr_write_data[1:0];
         CSR_IMAGE_WIDTH:   width     = csr_write_data[15:0];
         CSR_IMAGE_HEIGHT:  height    = csr_write_data[15:0];
         CSR_SRC_ROW_BYTES: src_pitch = csr_write_data[17:0];
         CSR_DST_ROW_BYTES: dst_pitch = csr_write_data[17:0];
         default: ;
      endcase
   endtask

   // take one source byte; queue the destination words of a finished pixel
   task automatic convert_byte(input logic [7:0] src_value);
      logic [3:0]               fmt;
      int                       ssz;
      int                       dsz;
      logic [7:0]               part [0:3];
      logic [7:0]               dst_out [0:3];
      logic [7:0]               red;
      logic [7:0]               green;
      logic [7:0]               blue;
      logic [7:0]               hi;
      logic [7:0]               lo;
      bit                       row_end;
      bit                       frame_end;
      longint                   slen;
      longint                   dlen;
      logic [DST_ADDR_BITS-1:0] step;
      dst_word_type             word;

      if (width == 0 || height == 0) return;
      // drop row padding
      if (pad_left != 0) begin
         pad_left = pad_left - 18'd1;
         return;
      end

      fmt = (src_fmt > SRC_BGR032) ? 4'(SRC_RGB24) : src_fmt;
      if (fmt == SRC_RGB24 || fmt == SRC_BGR24) ssz = 3;
      else if (fmt <= SRC_BGR16LE) ssz = 2;
      else ssz = 4;

      // hold partial pixels
      if (byte_count + 1 < ssz) begin
         held_bytes = held_bytes | (24'(src_value) << (8 * byte_count));
         byte_count = byte_count + 2'd1;
         return;
      end

      for (int i = 0; i < 3; i++) part[i] = held_bytes[8*i +: 8];
      part[3] = 8'h00;
      part[ssz-1] = src_value;

      // unpack to 8-bit channels
      hi = part[0];
      lo = part[1];
      if (fmt == SRC_RGB16LE || fmt == SRC_BGR16LE) begin
         hi = part[1];
         lo = part[0];
      end
      case (fmt)
         SRC_BGR24, SRC_BGRA32, SRC_BGR032: begin
            blue = part[0]; green = part[1]; red = part[2];
         end
         SRC_RGB16BE, SRC_RGB16LE: begin
            red   = {hi[7:3], 3'b000};
            green = {hi[2:0], lo[7:5], 2'b00};
            blue  = {lo[4:0], 3'b000};
         end
         SRC_BGR16BE, SRC_BGR16LE: begin
            blue  = {hi[7:3], 3'b000};
            green = {hi[2:0], lo[7:5], 2'b00};
            red   = {lo[4:0], 3'b000};
         end
         SRC_ARGB32: begin
            red = part[1]; green = part[2]; blue = part[3];
         end
         SRC_ABGR32: begin
            blue = part[1]; green = part[2]; red = part[3];
         end
         default: begin
            red = part[0]; green = part[1]; blue = part[2];
         end
      endcase

      // pack to the destination layout
      case (dst_fmt)
         DST_ARGB32: begin
            dst_out[0] = 8'hFF; dst_out[1] = red; dst_out[2] = green; dst_out[3] = blue;
            dsz = 4;
         end
         DST_RGB565: begin
            dst_out[0] = {green[4:2], blue[7:3]};
            dst_out[1] = {red[7:3], green[7:5]};
            dst_out[2] = 8'h00; dst_out[3] = 8'h00;
            dsz = 2;
         end
         default: begin
            dst_out[0] = blue; dst_out[1] = green; dst_out[2] = red; dst_out[3] = 8'h00;
            dsz = 4;
         end
      endcase

      row_end   = (column + 1 >= width);
      frame_end = row_end && (row + 1 >= height);

      for (int i = 0; i < dsz; i++) begin
         word.value     = dst_out[i];
         word.offset    = pixel_offset + DST_ADDR_BITS'(i);
         word.pixel_end = (i + 1 == dsz);
         word.image_end = (i + 1 == dsz) && frame_end;
         expected_words.push_back(word);
      end

      // advance the position
      byte_count = '0;
      held_bytes = '0;
      if (row_end) begin
         slen = longint'(width) * ssz;
         dlen = longint'(width) * dsz;
         pad_left = (src_pitch > slen) ? 18'(longint'(src_pitch) - slen) : 18'd0;
         column = '0;
         if (frame_end) begin
            row = '0;
            row_base = '0;
         end else begin
            step = (dst_pitch > dlen) ? DST_ADDR_BITS'(dst_pitch) : DST_ADDR_BITS'(dlen);
            row = row + 16'd1;
            row_base = row_base + step;
         end
         pixel_offset = row_base;
      end else begin
         column = column + 16'd1;
         pixel_offset = pixel_offset + DST_ADDR_BITS'(dsz);
      end
   endtask

   // pop check first: a word leaving now stems from an earlier byte; a byte taken
   // at the same edge as a register write still sees the old settings
   always @(posedge clock) begin
      if (reset) begin
         src_fmt = 0; dst_fmt = 0; width = 0; height = 0; src_pitch = 0; dst_pitch = 0;
         byte_count = 0; held_bytes = 0; column = 0; row = 0; pad_left = 0;
         row_base = 0; pixel_offset = 0;
         expected_words.delete();
      end else begin
         if (rsp_pop && !rsp_empty) check_word();
         if (req_push && !req_full) convert_byte(req_src_byte);
         if (csr_write_enable) store_setting();
      end
      mismatch_count <= mismatches;
      words_waiting  <= expected_words.size();
      words_checked  <= checked;
   end

endmodule

>>> bench/pixel_format_converter_top_test.sv
// Testbench top for the pixel format converter: clock, reset, register setup, source
// byte stimulus and result popping. Depends on pfc_pkg, pixel_format_converter_top
// and pixel_format_converter_checker.
`timescale 1ns / 100ps

module pixel_format_converter_top_test;
   import pfc_pkg::*;

   localparam int SETTLE_CYCLES  = 16;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_ITEMS   = 90;
   localparam int MIN_PHASES     = 11;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_write_data = '0;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic [7:0]                req_src_byte = 8'h00;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic [7:0]                rsp_dst_byte;
   logic [DST_ADDR_BITS-1:0]  rsp_dst_addr;
   logic                      rsp_pixel_last;
   logic                      rsp_frame_last;

   int mismatch_count;
   int words_waiting;
   int words_checked;

   bit          steady_run = 1'b0;
   logic [15:0] cur_width  = 0;
   logic [15:0] cur_height = 0;
   int          bytes_pushed    = 0;
   int          bytes_converted = 0;
   int          settings_loaded = 0;
   int          cycle_count     = 0;

   pixel_format_converter_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_src_byte     (req_src_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_dst_byte     (rsp_dst_byte),
      .rsp_dst_addr     (rsp_dst_addr),
      .rsp_pixel_last   (rsp_pixel_last),
      .rsp_frame_last   (rsp_frame_last)
   );

   pixel_format_converter_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_src_byte     (req_src_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_dst_byte     (rsp_dst_byte),
      .rsp_dst_addr     (rsp_dst_addr),
      .rsp_pixel_last   (rsp_pixel_last),
      .rsp_frame_last   (rsp_frame_last),
      .mismatch_count   (mismatch_count),
      .words_waiting    (words_waiting),
      .words_checked    (words_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stall the result side about a quarter of the time, never in a steady run
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= steady_run || ($urandom_range(99) >= 24);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected", cycle_count,
                  words_waiting);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type index, input logic [17:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // write all six registers; only called while the block is idle
   task automatic load_settings(input logic [3:0] src, input logic [1:0] dst,
                                input logic [15:0] w, input logic [15:0] h,
                                input logic [17:0] src_span, input logic [17:0] dst_span);
      write_reg(CSR_SRC_FORMAT, 18'(src));
      write_reg(CSR_DST_FORMAT, 18'(dst));
      write_reg(CSR_IMAGE_WIDTH, 18'(w));
      write_reg(CSR_IMAGE_HEIGHT, 18'(h));
      write_reg(CSR_SRC_ROW_BYTES, src_span);
      write_reg(CSR_DST_ROW_BYTES, dst_span);
      csr_write_enable <= 1'b0;
      cur_width  = w;
      cur_height = h;
      settings_loaded++;
   endtask

   // push one source word, idling at random first
   task automatic push_byte(input logic [7:0] value);
      while (!steady_run && $urandom_range(99) < 24) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push     <= 1'b1;
      req_src_byte <= value;
      @(posedge clock);
      while (req_full) @(posedge clock);
      bytes_pushed++;
      if (cur_width != 0 && cur_height != 0) bytes_converted++;
   endtask

   // send count bytes of pattern, most significant first
   task automatic send_bytes(input logic [63:0] pattern, input int count);
      for (int i = count - 1; i >= 0; i--) push_byte(pattern[8*i +: 8]);
   endtask

   // hold the sender until every expected word is out and the pipe is quiet
   task automatic finish_phase();
      req_push <= 1'b0;
      @(posedge clock);
      while (words_waiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // whole frames of random bytes under random sizes and pitches
   task automatic run_random_phase(input logic [3:0] fmt);
      logic [1:0] dst;
      int w;
      int h;
      int ssz;
      int dsz;
      int slen;
      int dlen;
      int src_span;
      int dst_span;
      int frames;
      int row_span;
      dst = 2'($urandom_range(3));
      w   = ($urandom_range(7) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 2);
      h   = ($urandom_range(3) == 0) ? 2 : 1;
      if (fmt == SRC_RGB24 || fmt == SRC_BGR24 || fmt > SRC_BGR032) ssz = 3;
      else if (fmt <= SRC_BGR16LE) ssz = 2;
      else ssz = 4;
      dsz  = (dst == DST_RGB565) ? 2 : 4;
      slen = w * ssz;
      dlen = w * dsz;
      case ($urandom_range(3))
         0:       src_span = $urandom_range(0, slen - 1);
         1:       src_span = slen;
         2:       src_span = slen + $urandom_range(1, 6);
         default: src_span = $urandom_range(0, slen + 6);
      endcase
      case ($urandom_range(2))
         0:       dst_span = $urandom_range(0, dlen);
         1:       dst_span = dlen + $urandom_range(1, 64);
         default: dst_span = $urandom_range(0, 262143);
      endcase
      frames   = 1;
      row_span = (src_span > slen) ? src_span : slen;
      load_settings(fmt, dst, 16'(w), 16'(h), 18'(src_span), 18'(dst_span));
      repeat (frames * h * row_span) push_byte(8'($urandom_range(255)));
      finish_phase();
   endtask

   // an empty image swallows every byte
   task automatic run_noise_phase();
      if ($urandom_range(1) == 0)
         load_settings(4'($urandom_range(15)), 2'($urandom_range(3)), 16'd0,
                       16'($urandom_range(65535)), 18'($urandom_range(262143)),
                       18'($urandom_range(262143)));
      else
         load_settings(4'($urandom_range(15)), 2'($urandom_range(3)),
                       16'($urandom_range(65535)), 16'd0, 18'($urandom_range(262143)),
                       18'($urandom_range(262143)));
      repeat ($urandom_range(3, 6)) push_byte(8'($urandom_range(255)));
      finish_phase();
   endtask

   initial begin
      int phase;
      int random_start;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty images at the register extremes
      load_settings(SRC_BGR032, DST_ARGB32, 16'h0000, 16'hFFFF, 18'h3FFFF, 18'h3FFFF);
      send_bytes(64'h00FF5A, 3);
      finish_phase();
      load_settings(SRC_RGB24, DST_BGR032, 16'hFFFF, 16'h0000, 18'h00000, 18'h00000);
      send_bytes(64'hA5C3FF, 3);
      finish_phase();

      // two pixels with two pad bytes at the end of the row
      load_settings(SRC_RGB24, DST_BGR032, 16'd2, 16'd1, 18'd8, 18'd0);
      send_bytes(64'h00FF00FF00FFAA55, 8);
      finish_phase();

      // pitch below the row length, widest destination pitch
      load_settings(SRC_RGB16BE, DST_RGB565, 16'd1, 16'd2, 18'd1, 18'h3FFFF);
      send_bytes(64'hFFFF0000, 4);
      finish_phase();

      // unused format codes fall back to RGB24 and BGR032
      load_settings(4'hF, 2'd3, 16'd1, 16'd1, 18'd0, 18'd0);
      send_bytes(64'h123456, 3);
      finish_phase();

      // 16-bit source into a 32-bit destination, the slowest pairing
      load_settings(SRC_BGR16LE, DST_ARGB32, 16'd1, 16'd1, 18'd0, 18'd0);
      send_bytes(64'h5AA5, 2);
      finish_phase();

      // two one-pixel frames back to back
      load_settings(SRC_ARGB32, DST_RGB565, 16'd1, 16'd1, 18'd0, 18'd0);
      send_bytes(64'h807FC33C01FE10EF, 8);
      finish_phase();

      // random frames, source format stepping through the codes in order
      random_start = bytes_converted;
      phase = 0;
      while (bytes_converted - random_start < RANDOM_ITEMS || phase < MIN_PHASES) begin
         steady_run <= (phase >= 5 && phase < 8);
         if ($urandom_range(4) == 0) run_noise_phase();
         run_random_phase(4'(phase % 16));
         phase++;
      end
      steady_run <= 1'b0;
      finish_phase();

      $display("Covered %0d source bytes (%0d inside nonempty images) over %0d settings,",
               bytes_pushed, bytes_converted, settings_loaded);
      $display("with %0d destination words compared against prediction.", words_checked);
      if (mismatch_count == 0 && words_waiting == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/pfc_pkg.sv
rtl/core/pfc_front.sv
rtl/core/pfc_queue.sv
rtl/core/pfc_back.sv
rtl/core/pixel_format_converter_top.sv
bench/pixel_format_converter_checker.sv
bench/pixel_format_converter_top_test.sv
